FILE: rtl/core/distinct_subsequence_counter_core_defines.svh
// assertion macros used by the checker file dsc_checker.sv
// each macro samples on clk and is switched off while arst_n is low
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_CORE_DEFINES_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_CORE_DEFINES_SVH

// same-cycle implication
`define DSC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// shared constants and types for the distinct subsequence counter
// ----------------------------------------------------------------------------
package dsc_pkg;

	// pattern capacity, one cell per pattern position
	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W       = 8;
	localparam int CNT_W       = 64;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	// item kinds
	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	// state a cell hands to its right neighbour when the chain shifts
	typedef struct packed {
		logic             valid;
		logic             head;
		logic [SYM_W-1:0] sym;
	} cell_link_t;

	// control broadcast to every cell
	typedef struct packed {
		logic             shift;
		logic             update;
		logic             clear;
		logic [SYM_W-1:0] sym;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/dsc_cell.sv
// ----------------------------------------------------------------------------
// dsc_cell
// one pattern position: holds its symbol and the count of ways its prefix
// occurs so far; shifts right on a pattern append, adds the right
// neighbour's count on a matching text symbol
// ----------------------------------------------------------------------------
module dsc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dsc_pkg::cell_ctrl_t         ctrl,
	input  dsc_pkg::cell_link_t         link_in,
	input  logic [dsc_pkg::CNT_W-1:0]   cnt_in,
	input  logic [dsc_pkg::CNT_W-1:0]   cnt_right,
	output dsc_pkg::cell_link_t         link_out,
	output logic [dsc_pkg::CNT_W-1:0]   cnt_out,
	output logic [dsc_pkg::CNT_W-1:0]   cnt_nxt
);

	logic                      valid_q;
	logic                      head_q;
	logic [dsc_pkg::SYM_W-1:0] sym_q;
	logic [dsc_pkg::CNT_W-1:0] cnt_q;
	logic [dsc_pkg::CNT_W-1:0] base;
	logic [dsc_pkg::CNT_W-1:0] below;
	logic                      hit;

	// count update from old values, row optionally cleared first
	always_comb begin
		base  = ctrl.clear ? '0 : cnt_q;
		below = head_q ? dsc_pkg::CNT_W'(1) : (ctrl.clear ? '0 : cnt_right);
		hit   = (sym_q == ctrl.sym);
		cnt_nxt = base + (hit ? below : '0);
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			head_q  <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= link_in.valid;
			head_q  <= link_in.head;
		end
	end

	// symbol and count
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sym_q <= link_in.sym;
			cnt_q <= cnt_in;
		end else if (ctrl.update && valid_q) begin
			cnt_q <= cnt_nxt;
		end
	end

	assign link_out = '{valid: valid_q, head: head_q, sym: sym_q};
	assign cnt_out  = cnt_q;

endmodule

FILE: rtl/core/distinct_subsequence_counter_core.sv
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_core
// counts the distinct occurrences of a loaded pattern as a subsequence of a
// streamed text, one text symbol per beat, in a chain of per-position cells
// ----------------------------------------------------------------------------
// channel  | signals                               | direction
// item     | item_valid item_stall kind symbol     | in
//          | first last                            |
// result   | result_valid result_stall count       | out
//          | is_last pattern_overflow              |
//
// all cells update together, so a new item is taken in each cycle that
// the result register is free or being drained.
// a text beat shows its result in the cycle after acceptance.
// the pattern is held newest-first: cell 0 always holds the last position,
// so its count is the answer. no clearing pass after reset.
// item_stall is high only while a result waits and result_stall is high.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       kind,
	input  logic [dsc_pkg::SYM_W-1:0]  symbol,
	input  logic                       first,
	input  logic                       last,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [dsc_pkg::CNT_W-1:0]  count,
	output logic                       is_last,
	output logic                       pattern_overflow
);

	logic                      accept;
	logic                      pat_beat;
	logic                      txt_beat;
	logic                      full;
	logic                      head_new;
	logic [dsc_pkg::LEN_W-1:0] length_q;
	logic                      overflow_q;
	logic                      result_valid_q;
	logic [dsc_pkg::CNT_W-1:0] count_q;
	logic                      is_last_q;
	logic                      pattern_overflow_q;
	logic [dsc_pkg::CNT_W-1:0] cnt0_nxt;
	dsc_pkg::cell_ctrl_t       ctrl;

	dsc_pkg::cell_link_t       link_out [dsc_pkg::MAX_PATTERN];
	dsc_pkg::cell_link_t       link_in  [dsc_pkg::MAX_PATTERN];
	logic [dsc_pkg::CNT_W-1:0] cnt_out  [dsc_pkg::MAX_PATTERN];

	// handshake
	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign pat_beat   = accept && (kind == dsc_pkg::KIND_PATTERN);
	assign txt_beat   = accept && (kind == dsc_pkg::KIND_TEXT);
	assign full       = (length_q == dsc_pkg::MAX_LEN) && !first;
	assign head_new   = first || (length_q == '0);

	// broadcast control
	always_comb begin
		ctrl.shift  = pat_beat && !full;
		ctrl.update = txt_beat;
		ctrl.clear  = first;
		ctrl.sym    = symbol;
	end

	// cell chain
	for (genvar k = 0; k < dsc_pkg::MAX_PATTERN; k++) begin : g_cell
		if (k == 0) begin : g_in0
			assign link_in[k] = '{valid: 1'b1, head: head_new, sym: symbol};
		end else begin : g_ink
			assign link_in[k] = '{valid: link_out[k-1].valid && !first,
				head: link_out[k-1].head, sym: link_out[k-1].sym};
		end

		if (k == 0 && dsc_pkg::MAX_PATTERN == 1) begin : g_only
			dsc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.link_in   (link_in[k]),
				.cnt_in    ('0),
				.cnt_right ('0),
				.link_out  (link_out[k]),
				.cnt_out   (cnt_out[k]),
				.cnt_nxt   (cnt0_nxt)
			);
		end else if (k == 0) begin : g_first
			dsc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.link_in   (link_in[k]),
				.cnt_in    ('0),
				.cnt_right (cnt_out[k+1]),
				.link_out  (link_out[k]),
				.cnt_out   (cnt_out[k]),
				.cnt_nxt   (cnt0_nxt)
			);
		end else if (k == dsc_pkg::MAX_PATTERN - 1) begin : g_end
			dsc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.link_in   (link_in[k]),
				.cnt_in    (cnt_out[k-1]),
				.cnt_right ('0),
				.link_out  (link_out[k]),
				.cnt_out   (cnt_out[k]),
				.cnt_nxt   ()
			);
		end else begin : g_mid
			dsc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.link_in   (link_in[k]),
				.cnt_in    (cnt_out[k-1]),
				.cnt_right (cnt_out[k+1]),
				.link_out  (link_out[k]),
				.cnt_out   (cnt_out[k]),
				.cnt_nxt   ()
			);
		end
	end

	// pattern length and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (pat_beat) begin
			if (first) begin
				length_q   <= dsc_pkg::LEN_W'(1);
				overflow_q <= 1'b0;
			end else if (full) begin
				overflow_q <= 1'b1;
			end else begin
				length_q <= length_q + dsc_pkg::LEN_W'(1);
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (txt_beat) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (txt_beat) begin
			count_q            <= (length_q == '0) ? dsc_pkg::CNT_W'(1) : cnt0_nxt;
			is_last_q          <= last;
			pattern_overflow_q <= overflow_q;
		end
	end

	assign result_valid     = result_valid_q;
	assign count            = count_q;
	assign is_last          = is_last_q;
	assign pattern_overflow = pattern_overflow_q;

endmodule

FILE: rtl/core/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker
// port-level checks on the distinct subsequence counter, bound to the core
// ----------------------------------------------------------------------------
`include "distinct_subsequence_counter_core_defines.svh"

module dsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       kind,
	input logic                       last,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [dsc_pkg::CNT_W-1:0]  count,
	input logic                       is_last,
	input logic                       pattern_overflow
);

	logic pat_acc;
	logic txt_acc;

	assign pat_acc = item_valid && !item_stall && (kind == dsc_pkg::KIND_PATTERN);
	assign txt_acc = item_valid && !item_stall && (kind == dsc_pkg::KIND_TEXT);

	// a pattern beat never produces a result
	`DSC_ASSERT_NEXT(a_pat_no_result, pat_acc, !result_valid, "pattern beat gave a result")

	// a text beat gives its result next cycle with the last flag echoed
	`DSC_ASSERT_NEXT(a_txt_result, txt_acc, result_valid && (is_last == $past(last)),
		"text beat result missing or wrong last flag")

	// input is held back only by a waiting result
	`DSC_ASSERT_SAME(a_stall_cause, item_stall, result_valid && result_stall,
		"input stalled without a blocked result")

	// a stalled result holds its beat
	`DSC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(count) && $stable(pattern_overflow),
		"stalled result changed")

endmodule

bind distinct_subsequence_counter_core dsc_checker u_dsc_checker (.*);

FILE: tb/sv/distinct_subsequence_counter_core_tb.sv
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_core_tb
// drives pattern and text beats into the subsequence counter and checks every
// result beat against a row-at-a-time software copy of the prefix counts.
// a short scripted part covers reset, symbol extremes, append after text and
// a full pattern store; random sessions follow under three idling mixes and
// one long result hold-off that backs the block up into its input
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_core_tb;
	import dsc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	// one expected result beat
	typedef struct {
		logic [CNT_W-1:0] cnt;
		logic             last_flag;
		logic             ovf;
	} occurrence_t;

	// one scripted row; reps repeats the beat, first only on the opening one
	// and last only on the closing one
	typedef struct {
		logic             k;
		logic [SYM_W-1:0] s;
		logic             f;
		logic             l;
		int               reps;
		logic             typed;
		logic [CNT_W-1:0] cnt;
		logic             ovf;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic             kind = KIND_PATTERN;
	logic [SYM_W-1:0] symbol = '0;
	logic             first = 1'b0;
	logic             last = 1'b0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [CNT_W-1:0] count;
	logic             is_last;
	logic             pattern_overflow;

	// hand-typed expectation travelling with the beat
	logic             beat_typed = 1'b0;
	logic [CNT_W-1:0] beat_cnt = '0;
	logic             beat_ovf = 1'b0;

	// predictor state
	logic [SYM_W-1:0] pat_sym [MAX_PATTERN];
	logic [CNT_W-1:0] run_cnt [MAX_PATTERN];
	int               pat_len = 0;
	logic             pat_ovf = 1'b0;

	occurrence_t      awaited_counts [$];
	occurrence_t      oldest;
	logic [CNT_W-1:0] fresh_cnt;

	int               mismatches = 0;
	int               results_seen = 0;
	int               items_sent = 0;
	int               count_wraps = 0;
	int               overflow_results = 0;
	int               idle_pct = 0;
	int               stall_pct = 0;
	int               hold_left = 0;
	logic             hold_arm = 1'b0;
	logic             hold_done = 1'b0;
	int               cycles = 0;

	script_row_t      script [21];

	distinct_subsequence_counter_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.symbol           (symbol),
		.first            (first),
		.last             (last),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.count            (count),
		.is_last          (is_last),
		.pattern_overflow (pattern_overflow)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// append one pattern symbol, dropping it when the store is full
	task automatic load_pattern_symbol(input logic [SYM_W-1:0] s, input logic f);
		if (f) begin
			pat_len = 0;
			pat_ovf = 1'b0;
		end
		if (pat_len < MAX_PATTERN) begin
			pat_sym[pat_len] = s;
			run_cnt[pat_len] = '0;
			pat_len++;
		end else begin
			pat_ovf = 1'b1;
		end
	endtask

	// fold one text symbol into the prefix counts, longest prefix first so
	// every add sees the counts from before this symbol
	task automatic advance_text(input logic [SYM_W-1:0] s, input logic f,
			output logic [CNT_W-1:0] full);
		int j;
		logic [CNT_W-1:0] below;
		logic [CNT_W-1:0] sum;
		if (f) begin
			for (j = 0; j < MAX_PATTERN; j++)
				run_cnt[j] = '0;
		end
		for (j = pat_len; j > 0; j--) begin
			if (pat_sym[j-1] == s) begin
				below = (j == 1) ? CNT_W'(1) : run_cnt[j-2];
				sum = run_cnt[j-1] + below;
				if (sum < below)
					count_wraps++;
				run_cnt[j-1] = sum;
			end
		end
		full = (pat_len == 0) ? CNT_W'(1) : run_cnt[pat_len-1];
	endtask

	// result beats are checked, then item beats feed the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_counts.size() == 0) begin
					$error("result beat with no count waiting: count %0h", count);
					mismatches++;
				end else begin
					oldest = awaited_counts.pop_front();
					results_seen++;
					if (pattern_overflow)
						overflow_results++;
					if (count !== oldest.cnt) begin
						$error("count: expected %0h, actual %0h", oldest.cnt, count);
						mismatches++;
					end
					if (is_last !== oldest.last_flag) begin
						$error("is_last: expected %0b, actual %0b", oldest.last_flag, is_last);
						mismatches++;
					end
					if (pattern_overflow !== oldest.ovf) begin
						$error("pattern_overflow: expected %0b, actual %0b", oldest.ovf,
							pattern_overflow);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (kind == KIND_PATTERN) begin
					load_pattern_symbol(symbol, first);
				end else begin
					advance_text(symbol, first, fresh_cnt);
					if (beat_typed)
						awaited_counts.push_back('{beat_cnt, last, beat_ovf});
					else
						awaited_counts.push_back('{fresh_cnt, last, pat_ovf});
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// offer one beat, idling first at random, and return once it is taken
	task automatic offer_beat(input logic k, input logic [SYM_W-1:0] s, input logic f,
			input logic l, input logic typed, input logic [CNT_W-1:0] c, input logic o);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		symbol     <= s;
		first      <= f;
		last       <= l;
		beat_typed <= typed;
		beat_cnt   <= c;
		beat_ovf   <= o;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] base,
			input int span);
		return SYM_W'(base + SYM_W'($urandom_range(span - 1)));
	endfunction

	// one random session: mostly a well-formed pattern then text, with the
	// odd append after text, otherwise unframed beats or pure noise
	task automatic run_session();
		int choice;
		int plen;
		int tlen;
		int span;
		int n;
		int i;
		logic [SYM_W-1:0] base;
		logic [SYM_W-1:0] s;
		choice = $urandom_range(99);
		base = SYM_W'($urandom_range(255));
		if (choice < 75) begin
			n = $urandom_range(99);
			if (n < 70)
				plen = $urandom_range(1, 6);
			else if (n < 90)
				plen = $urandom_range(7, 20);
			else if (n < 97)
				plen = $urandom_range(21, 64);
			else
				plen = $urandom_range(65, 68);
			span = ($urandom_range(9) == 0) ? 256 : $urandom_range(1, 3);
			if (span == 1 && $urandom_range(1) == 1)
				tlen = $urandom_range(40, 100);
			else if ($urandom_range(9) == 0)
				tlen = $urandom_range(60, 100);
			else
				tlen = $urandom_range(1, 30);
			for (i = 0; i < plen; i++)
				offer_beat(KIND_PATTERN, pick_symbol(base, span), i == 0,
					1'($urandom_range(1)), 1'b0, '0, 1'b0);
			for (i = 0; i < tlen; i++) begin
				s = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255))
					: pick_symbol(base, span);
				offer_beat(KIND_TEXT, s, i == 0, i == tlen - 1, 1'b0, '0, 1'b0);
			end
			// longer pattern after some text has gone by
			if ($urandom_range(6) == 0) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					offer_beat(KIND_PATTERN, pick_symbol(base, span), 1'b0, 1'b0,
						1'b0, '0, 1'b0);
				n = $urandom_range(1, 10);
				for (i = 0; i < n; i++)
					offer_beat(KIND_TEXT, pick_symbol(base, span), 1'b0, i == n - 1,
						1'b0, '0, 1'b0);
			end
		end else if (choice < 90) begin
			span = $urandom_range(1, 4);
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				offer_beat(1'($urandom_range(1)), pick_symbol(base, span), 1'b0,
					1'($urandom_range(1)), 1'b0, '0, 1'b0);
		end else begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				offer_beat(1'($urandom_range(1)), SYM_W'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0, 1'b0);
		end
	endtask

	// stimulus
	initial begin
		int r;
		int i;
		int start;
		script = '{
			// empty pattern straight after reset
			'{KIND_TEXT,    8'h00, 1'b0, 1'b0,  1, 1'b1, 64'd1, 1'b0},
			'{KIND_TEXT,    8'hff, 1'b1, 1'b1,  1, 1'b1, 64'd1, 1'b0},
			// single-symbol pattern
			'{KIND_PATTERN, 8'h61, 1'b1, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'h61, 1'b1, 1'b0,  1, 1'b1, 64'd1, 1'b0},
			'{KIND_TEXT,    8'h61, 1'b0, 1'b0,  1, 1'b1, 64'd2, 1'b0},
			'{KIND_TEXT,    8'h62, 1'b0, 1'b1,  1, 1'b1, 64'd2, 1'b0},
			// symbol extremes
			'{KIND_PATTERN, 8'h00, 1'b1, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_PATTERN, 8'hff, 1'b0, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'hff, 1'b1, 1'b0,  1, 1'b1, 64'd0, 1'b0},
			'{KIND_TEXT,    8'h00, 1'b0, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'hff, 1'b0, 1'b1,  1, 1'b0, 64'd0, 1'b0},
			// append after text
			'{KIND_PATTERN, 8'h61, 1'b0, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'h61, 1'b0, 1'b1,  1, 1'b0, 64'd0, 1'b0},
			// full store, then dropped symbols
			'{KIND_PATTERN, 8'h41, 1'b1, 1'b0, 64, 1'b0, 64'd0, 1'b0},
			'{KIND_PATTERN, 8'h42, 1'b0, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'h41, 1'b1, 1'b0,  1, 1'b1, 64'd0, 1'b1},
			'{KIND_TEXT,    8'h41, 1'b0, 1'b1, 63, 1'b0, 64'd0, 1'b0},
			'{KIND_PATTERN, 8'h5a, 1'b0, 1'b1,  1, 1'b0, 64'd0, 1'b0},
			// fresh pattern clears the overflow flag
			'{KIND_PATTERN, 8'h80, 1'b1, 1'b0,  1, 1'b0, 64'd0, 1'b0},
			'{KIND_TEXT,    8'h80, 1'b0, 1'b1,  1, 1'b1, 64'd1, 1'b0},
			'{KIND_TEXT,    8'h7f, 1'b0, 1'b0,  1, 1'b0, 64'd0, 1'b0}
		};
		for (i = 0; i < MAX_PATTERN; i++) begin
			pat_sym[i] = '0;
			run_cnt[i] = '0;
		end

		// reset
		idle_pct  = 20;
		stall_pct = 77;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted beats
		for (r = 0; r < $size(script); r++) begin
			for (i = 0; i < script[r].reps; i++)
				offer_beat(script[r].k, script[r].s, script[r].f && i == 0,
					script[r].l && i == script[r].reps - 1, script[r].typed,
					script[r].cnt, script[r].ovf);
		end

		// random sessions under three idling mixes
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start >= 2 * RANDOM_ITEMS / 3) begin
				idle_pct  = 0;
				stall_pct = 0;
				hold_arm <= 1'b1;
			end else if (items_sent - start >= RANDOM_ITEMS / 3) begin
				idle_pct  = 77;
				stall_pct = 20;
			end
			run_session();
		end
		item_valid <= 1'b0;

		// drain
		while (awaited_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d beats sent, %0d results checked", items_sent, results_seen);
		$display("tb: %0d count wraps past 2^64, %0d results with pattern overflow",
			count_wraps, overflow_results);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dsc_pkg.sv
rtl/core/dsc_cell.sv
rtl/core/distinct_subsequence_counter_core.sv
rtl/core/dsc_checker.sv
tb/sv/distinct_subsequence_counter_core_tb.sv
